// ===== sv/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, widths and constants shared by the gas sensor calibrator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

  localparam int FRACTION_BITS = 15;

  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 14;
  localparam int EFF_W    = 13;
  localparam int SLOPE_W  = 16;
  localparam int REF_W    = 9;
  localparam int DENS_W   = 10;
  localparam int STATUS_W = 2;
  localparam int DMASK_W  = 9;

  localparam int NUM_W   = REF_W + FRACTION_BITS;
  localparam int PROD_W  = SLOPE_W + EFF_W;
  localparam int REM_W   = EFF_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int KPROD_W = DMASK_W + 8;

  localparam int SAMPLE_NEG_BIT = EFF_W;

  localparam logic [EFF_W-1:0]   MIN_SPAN  = EFF_W'(500);
  localparam logic [DMASK_W-1:0] KNEE      = DMASK_W'(200);
  localparam logic [7:0]         RECIP5    = 8'd205;
  localparam int                 RECIP5_SH = 10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE = 2'd0,
    FUNC_ZERO    = 2'd1,
    FUNC_CAL     = 2'd2,
    FUNC_RESTORE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_SPAN  = 2'd2
  } status_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_KNEE = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

`default_nettype wire

// ===== sv/gas_sensor_offset_slope_calibrator.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_offset_slope_calibrator
// Two-point linear calibration of a gas sensor: measure, zero, span, restore.
// ----------------------------------------------------------------------------
// One item in, one result out. A shared shift-add/subtract unit that retires
// one bit per cycle runs 13 multiply steps for a measure, followed by the
// knee correction, and 24 divide steps for a successful calibrate; zero
// adjust, restore and a failed calibrate do not use it. Each result is held
// while out_stall is high. The input stalls until the result is taken. The
// user must write the reference density through the cfg channel only while
// no item is in flight; the block itself does not enforce it.
`default_nettype none

module gas_sensor_offset_slope_calibrator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gsc_pkg::FUNC_W-1:0]    in_func,
  input  logic [gsc_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  logic [gsc_pkg::SLOPE_W-1:0]   in_restore_slope,
  input  logic [gsc_pkg::EFF_W-1:0]     in_restore_zero,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gsc_pkg::DENS_W-1:0]    out_density,
  output logic [gsc_pkg::STATUS_W-1:0]  out_status,
  output logic [gsc_pkg::SLOPE_W-1:0]   out_slope_now,
  output logic [gsc_pkg::EFF_W-1:0]     out_zero_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gsc_pkg::REF_W-1:0]     cfg_reference_density
);
  import gsc_pkg::*;

  logic [REF_W-1:0]  ref_r, ref_nxt;
  alu_ctl_t          alu_ctl;
  alu_sts_t          alu_sts;
  logic [SLOPE_W-1:0] alu_opa;
  logic [EFF_W-1:0]  alu_opb;
  logic [NUM_W-1:0]  alu_num;
  logic [PROD_W-1:0] alu_prod;
  logic [NUM_W-1:0]  alu_quot;

  assign cfg_ready = 1'b1;

  always_comb begin
    ref_nxt = ref_r;
    if (cfg_valid && cfg_ready) begin
      ref_nxt = cfg_reference_density;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else begin
      ref_r <= ref_nxt;
    end
  end

  gsc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_adc_sample    (in_adc_sample),
    .in_restore_slope (in_restore_slope),
    .in_restore_zero  (in_restore_zero),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_density      (out_density),
    .out_status       (out_status),
    .out_slope_now    (out_slope_now),
    .out_zero_now     (out_zero_now),
    .ref_density      (ref_r),
    .alu_ctl          (alu_ctl),
    .alu_opa          (alu_opa),
    .alu_opb          (alu_opb),
    .alu_num          (alu_num),
    .alu_sts          (alu_sts),
    .alu_prod         (alu_prod),
    .alu_quot         (alu_quot)
  );

  gsc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (alu_opa),
    .opb   (alu_opb),
    .num   (alu_num),
    .sts   (alu_sts),
    .prod  (alu_prod),
    .quot  (alu_quot)
  );

endmodule

`default_nettype wire

// ===== sv/gsc_alu.sv =====
// ----------------------------------------------------------------------------
// gsc_alu
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsc_pkg::alu_ctl_t             ctl,
  input  logic [gsc_pkg::SLOPE_W-1:0]   opa,
  input  logic [gsc_pkg::EFF_W-1:0]     opb,
  input  logic [gsc_pkg::NUM_W-1:0]     num,
  output gsc_pkg::alu_sts_t             sts,
  output logic [gsc_pkg::PROD_W-1:0]    prod,
  output logic [gsc_pkg::NUM_W-1:0]     quot
);
  import gsc_pkg::*;

  alu_op_t             op_r, op_nxt;
  logic [SLOPE_W-1:0]  md_r, md_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [NUM_W-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [REM_W-1:0]    rem_sh;
  logic [SUM_W-1:0]    add_a, add_b, sum;
  logic                cin;

  always_comb begin
    rem_sh = {acc_r[REM_W-2:0], sh_r[NUM_W-1]};
    if (op_r == ALU_MUL) begin
      add_a = {acc_r, 1'b0};
      add_b = sh_r[NUM_W-1] ? SUM_W'(md_r) : '0;
      cin   = 1'b0;
    end else begin
      add_a = SUM_W'(rem_sh);
      add_b = ~SUM_W'(md_r);
      cin   = 1'b1;
    end
    sum = add_a + add_b + {{(SUM_W-1){1'b0}}, cin};
  end

  always_comb begin
    op_nxt   = op_r;
    md_nxt   = md_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start && !busy_r) begin
      op_nxt   = ctl.op;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
      if (ctl.op == ALU_MUL) begin
        md_nxt  = opa;
        sh_nxt  = {opb, {(NUM_W-EFF_W){1'b0}}};
        cnt_nxt = CNT_W'(EFF_W);
      end else begin
        md_nxt  = SLOPE_W'(opb);
        sh_nxt  = num;
        cnt_nxt = CNT_W'(NUM_W);
      end
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        acc_nxt = sum[PROD_W-1:0];
        sh_nxt  = {sh_r[NUM_W-2:0], 1'b0};
      end else begin
        acc_nxt = sum[SUM_W-1] ? PROD_W'(rem_sh) : PROD_W'(sum[REM_W-1:0]);
        sh_nxt  = {sh_r[NUM_W-2:0], ~sum[SUM_W-1]};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ALU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    md_r  <= md_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;
  assign quot     = sh_r;

endmodule

`default_nettype wire

// ===== sv/gsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsc_ctrl
// Sequencer: decodes each item, holds offset and slope, drives the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gsc_pkg::FUNC_W-1:0]    in_func,
  input  logic [gsc_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  logic [gsc_pkg::SLOPE_W-1:0]   in_restore_slope,
  input  logic [gsc_pkg::EFF_W-1:0]     in_restore_zero,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gsc_pkg::DENS_W-1:0]    out_density,
  output logic [gsc_pkg::STATUS_W-1:0]  out_status,
  output logic [gsc_pkg::SLOPE_W-1:0]   out_slope_now,
  output logic [gsc_pkg::EFF_W-1:0]     out_zero_now,
  input  logic [gsc_pkg::REF_W-1:0]     ref_density,
  output gsc_pkg::alu_ctl_t             alu_ctl,
  output logic [gsc_pkg::SLOPE_W-1:0]   alu_opa,
  output logic [gsc_pkg::EFF_W-1:0]     alu_opb,
  output logic [gsc_pkg::NUM_W-1:0]     alu_num,
  input  gsc_pkg::alu_sts_t             alu_sts,
  input  logic [gsc_pkg::PROD_W-1:0]    alu_prod,
  input  logic [gsc_pkg::NUM_W-1:0]     alu_quot
);
  import gsc_pkg::*;

  state_t              state_r, state_nxt;
  func_t               func_r, func_nxt;
  logic [EFF_W-1:0]    zero_r, zero_nxt;
  logic [SLOPE_W-1:0]  slope_r, slope_nxt;
  logic [DENS_W-1:0]   dens_r, dens_nxt;
  status_t             status_r, status_nxt;
  logic [DMASK_W-1:0]  d_r, d_nxt;

  logic [EFF_W-1:0]    eff;
  logic [EFF_W-1:0]    span;
  logic [DMASK_W-1:0]  knee_x;
  logic [KPROD_W-1:0]  knee_p;
  logic [DENS_W-1:0]   knee_q;

  always_comb begin
    eff    = in_adc_sample[SAMPLE_NEG_BIT] ? '0 : in_adc_sample[EFF_W-1:0];
    span   = eff - zero_r;
    knee_x = d_r - KNEE;
    knee_p = KPROD_W'(knee_x) * KPROD_W'(RECIP5);
    knee_q = DENS_W'(knee_p >> RECIP5_SH);
  end

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    zero_nxt   = zero_r;
    slope_nxt  = slope_r;
    dens_nxt   = dens_r;
    status_nxt = status_r;
    d_nxt      = d_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = ALU_MUL;
    alu_opa    = slope_r;
    alu_opb    = (eff > zero_r) ? span : '0;
    alu_num    = {ref_density, 1'b1, {(FRACTION_BITS-1){1'b0}}};
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_nxt   = func_t'(in_func);
          dens_nxt   = '0;
          status_nxt = ST_OK;
          case (func_t'(in_func))
            FUNC_MEASURE: begin
              alu_ctl.start = 1'b1;
              alu_ctl.op    = ALU_MUL;
              state_nxt     = S_RUN;
            end
            FUNC_ZERO: begin
              zero_nxt  = eff;
              state_nxt = S_OUT;
            end
            FUNC_CAL: begin
              alu_opb = span;
              if (eff < zero_r) begin
                status_nxt = ST_BELOW;
                state_nxt  = S_OUT;
              end else if (span < MIN_SPAN) begin
                status_nxt = ST_SPAN;
                state_nxt  = S_OUT;
              end else begin
                alu_ctl.start = 1'b1;
                alu_ctl.op    = ALU_DIV;
                state_nxt     = S_RUN;
              end
            end
            FUNC_RESTORE: begin
              slope_nxt = in_restore_slope;
              zero_nxt  = in_restore_zero;
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_RUN: begin
        if (alu_sts.done) begin
          if (func_r == FUNC_MEASURE) begin
            d_nxt     = alu_prod[FRACTION_BITS +: DMASK_W];
            state_nxt = S_KNEE;
          end else begin
            slope_nxt = (|alu_quot[NUM_W-1:SLOPE_W]) ? '1 : alu_quot[SLOPE_W-1:0];
            state_nxt = S_OUT;
          end
        end
      end
      S_KNEE: begin
        dens_nxt  = (d_r > KNEE) ? DENS_W'(d_r) + knee_q : DENS_W'(d_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      zero_r  <= '0;
      slope_r <= '0;
    end else begin
      state_r <= state_nxt;
      zero_r  <= zero_nxt;
      slope_r <= slope_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    dens_r   <= dens_nxt;
    status_r <= status_nxt;
    d_r      <= d_nxt;
  end

  assign out_density   = dens_r;
  assign out_status    = status_r;
  assign out_slope_now = slope_r;
  assign out_zero_now  = zero_r;

endmodule

`default_nettype wire

// ===== sv/gsc_chk.sv =====
// ----------------------------------------------------------------------------
// gsc_chk
// Port-level checks for the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gsc_pkg::DENS_W-1:0]    out_density,
  input logic [gsc_pkg::STATUS_W-1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_density) && $stable(out_status))
    else $error("stalled item changed");

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while item pending");

  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken without a result");

  a_fail_no_density: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gsc_pkg::ST_OK |-> out_density == '0)
    else $error("failed calibrate gave density");

endmodule

bind gas_sensor_offset_slope_calibrator gsc_chk u_gsc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_density (out_density),
  .out_status  (out_status)
);

`default_nettype wire
